// ===== src/assq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assq_pkg
// Types and constants shared by the arrival-sorted service queue and its
// checker.
// ----------------------------------------------------------------------------
package assq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [7:0]  customer_name;
		logic [7:0]  customer_tag;
		logic [31:0] arrival_time;
		logic [15:0] service_time;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  served_name;
		logic [7:0]  served_tag;
		logic [31:0] served_arrival;
		logic [31:0] start_time;
		logic [31:0] finish_time;
		logic [31:0] delay_time;
		logic [4:0]  occupancy;
	} result_t;

	typedef struct packed {
		logic [7:0]  name;
		logic [7:0]  tag;
		logic [31:0] arrival;
		logic [15:0] service;
	} entry_t;

endpackage

// ===== src/arrival_sorted_service_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrival_sorted_service_queue
// Bounded queue sorted by arrival time that feeds a single server clock.
// ----------------------------------------------------------------------------
// Channel   Signals                Direction  Beat taken when
// command   start, busy, cmd       in         start && !busy at clk rise
// result    done, result           out        done high, one cycle, no stall
//
// A refused enqueue or an empty dequeue gives its result in the cycle after
// the command beat without raising busy. An enqueue holds busy while it moves
// entries one at a time, since the single memory read port and one arrival
// comparator look at one entry per pass through the check and compare states.
// A dequeue holds busy in three states: read, clock compare, end and wait sums.
// Reset clears the count, head and server clock; the entry memory is not
// cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module arrival_sorted_service_queue
	import assq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_ENQ_CHK = 6'b000010,
		S_ENQ_CMP = 6'b000100,
		S_DEQ_RD  = 6'b001000,
		S_DEQ_SRV = 6'b010000,
		S_DEQ_OUT = 6'b100000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   pos_q;
	logic [CW-1:0]   pos_m1;
	logic [AW-1:0]   head_q;
	logic [31:0]     clock_q;
	logic [31:0]     start_q;
	logic [31:0]     end_sum;
	logic            done_q;
	result_t         res_q;
	entry_t          new_q;
	entry_t          srv_q;
	entry_t          rd_q;
	entry_t          mem [QUEUE_DEPTH];
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [AW-1:0]   mem_raddr;
	entry_t          mem_wdata;
	logic            later;

	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [AW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (AW+1)'(QUEUE_DEPTH)) begin
			s = s - (AW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	function automatic result_t short_result(input logic [1:0] st, input logic [4:0] occ);
		result_t r;
		r           = '0;
		r.status    = st;
		r.occupancy = occ;
		return r;
	endfunction

	assign pos_m1  = pos_q - CW'(1);
	assign later   = rd_q.arrival > new_q.arrival;
	assign end_sum = start_q + 32'(srv_q.service);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wrap(head_q, pos_q[AW-1:0]);
		mem_wdata = new_q;
		mem_raddr = wrap(head_q, pos_m1[AW-1:0]);
		case (state_q)
			S_ENQ_CHK: begin
				mem_we = (pos_q == '0);
			end
			S_ENQ_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = later ? rd_q : new_q;
			end
			S_DEQ_RD: begin
				mem_raddr = head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			head_q  <= '0;
			clock_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cmd.kind == KIND_ENQ) begin
							if (count_q == CW'(QUEUE_DEPTH)) begin
								res_q  <= short_result(ST_FULL, 5'(count_q));
								done_q <= 1'b1;
							end else begin
								new_q   <= '{name: cmd.customer_name, tag: cmd.customer_tag,
								             arrival: cmd.arrival_time,
								             service: cmd.service_time};
								pos_q   <= count_q;
								state_q <= S_ENQ_CHK;
							end
						end else begin
							if (count_q == '0) begin
								res_q  <= short_result(ST_EMPTY, 5'(count_q));
								done_q <= 1'b1;
							end else begin
								state_q <= S_DEQ_RD;
							end
						end
					end
				end
				S_ENQ_CHK: begin
					if (pos_q == '0) begin
						count_q <= count_q + CW'(1);
						res_q   <= short_result(ST_OK, 5'(count_q + CW'(1)));
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ENQ_CMP;
					end
				end
				S_ENQ_CMP: begin
					if (later) begin
						pos_q   <= pos_m1;
						state_q <= S_ENQ_CHK;
					end else begin
						count_q <= count_q + CW'(1);
						res_q   <= short_result(ST_OK, 5'(count_q + CW'(1)));
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DEQ_RD: begin
					state_q <= S_DEQ_SRV;
				end
				S_DEQ_SRV: begin
					srv_q   <= rd_q;
					start_q <= (rd_q.arrival > clock_q) ? rd_q.arrival : clock_q;
					count_q <= count_q - CW'(1);
					head_q  <= (count_q == CW'(1)) ? '0 : wrap(head_q, AW'(1));
					state_q <= S_DEQ_OUT;
				end
				S_DEQ_OUT: begin
					clock_q              <= end_sum;
					res_q.status         <= ST_OK;
					res_q.served_name    <= srv_q.name;
					res_q.served_tag     <= srv_q.tag;
					res_q.served_arrival <= srv_q.arrival;
					res_q.start_time     <= start_q;
					res_q.finish_time    <= end_sum;
					res_q.delay_time     <= start_q - srv_q.arrival;
					res_q.occupancy      <= 5'(count_q);
					done_q               <= 1'b1;
					state_q              <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== src/assq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assq_checker
// Port-level checks for the arrival-sorted service queue, bound to the top.
// ----------------------------------------------------------------------------
module assq_checker
	import assq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted command neither started work nor gave a result");

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result beat without a command in flight");

	a_empty_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_EMPTY |-> result.occupancy == 5'd0)
		else $error("empty dequeue reports entries held");

	a_full_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_FULL |-> result.occupancy == 5'(QUEUE_DEPTH))
		else $error("refused enqueue reports a queue that is not full");

	a_wait_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.delay_time == result.start_time - result.served_arrival)
		else $error("wait time does not match start minus arrival");

endmodule

bind arrival_sorted_service_queue assq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_assq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
